// ===== hw/rtl/bst_pkg.sv =====
// Shared widths, opcodes and status codes of the bounded set table.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int OP_W = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

// ===== hw/rtl/bst_mem.sv =====
// Entry store of the set table: one write port and one registered read port.
`timescale 1ns / 1ps

module bst_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bst_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bst_pkg::VALUE_W-1:0] rdata
);
  import bst_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bounded_set_table_unit.sv =====
// Top level of the bounded set table: sequencer, compare unit and result register.
`timescale 1ns / 1ps

// Bounded set table. Holds up to CAPACITY signed 32-bit values packed in slots
// 0 .. count-1. Each input word carries an opcode in s_tuser (insert, remove,
// query; the unused code acts as a query) and a value in s_tdata, and yields
// exactly one result word: found, count after the operation, and status. The
// block takes one word at a time, accepting it in the idle state. A single
// equality comparator walks the stored entries one per cycle through the read
// port of the entry memory. Insert and query then finish without further
// memory reads. A remove that hits compacts the table by moving each later
// entry down one slot, one move per cycle on the same memory ports. The result
// waits in an output register, so a new word is taken while the previous
// result is still pending. No clearing pass is needed after reset.
module bounded_set_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bst_pkg::VALUE_W-1:0]    s_tdata,  // [31:0] value
  input  logic [bst_pkg::OP_W-1:0]       s_tuser,  // [1:0] opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bst_pkg::OUT_DATA_W-1:0] m_tdata   // [0] found, [5:1] count, [7:6] status
);
  import bst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op;
  logic [VALUE_W-1:0]  value;
  logic [CW-1:0]       entry_count;
  logic [CW-1:0]       rd_idx;
  logic [CW-1:0]       cmp_idx;
  logic                cmp_vld;
  logic [CW-1:0]       pos;
  logic                hit;
  logic [AW-1:0]       wr_idx;
  logic [STATUS_W-1:0] res_status;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [VALUE_W-1:0]  mem_rdata;
  logic                match;
  logic                more;
  logic [CW+4:0]       count_ext;

  bst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign match = cmp_vld && (mem_rdata == value);
  assign more = (rd_idx < entry_count);
  assign mem_re = ((state == S_SEARCH) || (state == S_SHIFT)) && more;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = mem_rdata;
    if (state == S_DECIDE && op == OP_INSERT && entry_count < CW'(CAPACITY)) begin
      mem_we = 1'b1;
      mem_waddr = entry_count[AW-1:0];
      mem_wdata = value;
    end else if (state == S_SHIFT && cmp_vld) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      m_tvalid <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            value <= s_tdata;
            rd_idx <= '0;
            cmp_vld <= 1'b0;
            hit <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Reads run one entry ahead of the comparator.
          if (match) begin
            hit <= 1'b1;
            pos <= cmp_idx;
            cmp_vld <= 1'b0;
            state <= S_DECIDE;
          end else if (!more && !cmp_vld) begin
            state <= S_DECIDE;
          end else begin
            cmp_vld <= more;
            cmp_idx <= rd_idx;
            if (more) begin
              rd_idx <= rd_idx + CW'(1);
            end
          end
        end
        S_DECIDE: begin
          case (op)
            OP_INSERT: begin
              state <= S_FINISH;
              if (entry_count < CW'(CAPACITY)) begin
                entry_count <= entry_count + CW'(1);
                res_status <= ST_OK;
              end else begin
                res_status <= ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                res_status <= ST_OK;
                rd_idx <= pos + CW'(1);
                wr_idx <= pos[AW-1:0];
                cmp_vld <= 1'b0;
                state <= S_SHIFT;
              end else begin
                res_status <= ST_MISSING;
                state <= S_FINISH;
              end
            end
            default: begin
              res_status <= ST_OK;
              state <= S_FINISH;
            end
          endcase
        end
        S_SHIFT: begin
          // Each entry read one cycle is written one slot lower the next.
          if (cmp_vld) begin
            wr_idx <= wr_idx + AW'(1);
          end
          if (!more && !cmp_vld) begin
            entry_count <= entry_count - CW'(1);
            state <= S_FINISH;
          end else begin
            cmp_vld <= more;
            if (more) begin
              rd_idx <= rd_idx + CW'(1);
            end
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {res_status, count_ext[COUNT_W-1:0], hit};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = {5'd0, entry_count};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_idle_count_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> $stable(entry_count))
    else $error("entry count changed while idle");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_status == ST_FULL) |-> entry_count == CW'(CAPACITY))
    else $error("full status with room left");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && mem_we) |-> ({1'b0, wr_idx} + (AW+1)'(1)) < (AW+1)'(entry_count))
    else $error("compaction write beyond the last entry");
`endif

endmodule

// ===== test/tb_bounded_set_table_unit.sv =====
// Self-checking testbench for the bounded set table with a behavioral table predictor.
`timescale 1ns / 1ps

module tb_bounded_set_table_unit;
  import bst_pkg::*;

  localparam int CAPACITY = 16;
  localparam int RANDOM_WORDS = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_N = 12;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                found;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;
    logic [4:0]          reps;
    logic                typed;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } step_t;

  // A row with reps above one walks value, value + 1, ... and relies on the predictor.
  localparam step_t DIRECTED [24] = '{
    '{OP_QUERY,   32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd0,  ST_OK},
    '{OP_REMOVE,  32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd0,  ST_MISSING},
    '{OP_INSERT,  32'h8000_0000, 5'd1,  1'b1, 1'b0, 5'd1,  ST_OK},
    '{OP_INSERT,  32'h7FFF_FFFF, 5'd1,  1'b1, 1'b0, 5'd2,  ST_OK},
    '{OP_INSERT,  32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 5'd3,  ST_OK},
    '{OP_SPARE,   32'h8000_0000, 5'd1,  1'b1, 1'b1, 5'd3,  ST_OK},
    '{OP_QUERY,   32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd3,  ST_OK},
    '{OP_REMOVE,  32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 5'd2,  ST_OK},
    '{OP_QUERY,   32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 5'd2,  ST_OK},
    '{OP_REMOVE,  32'h8000_0000, 5'd1,  1'b1, 1'b1, 5'd1,  ST_OK},
    '{OP_INSERT,  32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, 5'd2,  ST_OK},
    '{OP_INSERT,  32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd3,  ST_OK},
    '{OP_INSERT,  32'h0000_0001, 5'd13, 1'b0, 1'b0, 5'd0,  ST_OK},
    '{OP_INSERT,  32'h5555_AAAA, 5'd1,  1'b1, 1'b0, 5'd16, ST_FULL},
    '{OP_INSERT,  32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 5'd16, ST_FULL},
    '{OP_QUERY,   32'h0000_000D, 5'd1,  1'b1, 1'b1, 5'd16, ST_OK},
    '{OP_REMOVE,  32'h0000_000D, 5'd1,  1'b1, 1'b1, 5'd15, ST_OK},
    '{OP_INSERT,  32'hAAAA_5555, 5'd1,  1'b1, 1'b0, 5'd16, ST_OK},
    '{OP_REMOVE,  32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 5'd15, ST_OK},
    '{OP_REMOVE,  32'h0000_0006, 5'd1,  1'b0, 1'b0, 5'd0,  ST_OK},
    '{OP_REMOVE,  32'h0000_0006, 5'd1,  1'b1, 1'b0, 5'd14, ST_MISSING},
    '{OP_SPARE,   32'h1234_5678, 5'd1,  1'b1, 1'b0, 5'd14, ST_OK},
    '{OP_REMOVE,  32'h0000_0001, 5'd12, 1'b0, 1'b0, 5'd0,  ST_OK},
    '{OP_QUERY,   32'hAAAA_5555, 5'd1,  1'b0, 1'b0, 5'd0,  ST_OK}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata;  // [31:0] value
  logic [OP_W-1:0]       s_tuser;  // [1:0] opcode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // [0] found, [5:1] count, [7:6] status

  logic [VALUE_W-1:0] held_values [CAPACITY];
  int                 held_count;
  result_t            awaited_results [$];
  logic [VALUE_W-1:0] value_pool [POOL_N];
  int                 mismatches = 0;
  int                 quiet_cycles;
  bit                 tx_quiet;

  bounded_set_table_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one operation to the local copy of the table and returns its result.
  function automatic result_t apply_set_op(input logic [OP_W-1:0] op,
                                           input logic [VALUE_W-1:0] val);
    result_t r;
    int hit_at;
    int i;
    hit_at = -1;
    for (i = 0; i < held_count; i++) begin
      if (hit_at < 0 && held_values[i] == val) hit_at = i;
    end
    r.found = (hit_at >= 0);
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_values[held_count] = val;
        held_count++;
      end
    end else if (op == OP_REMOVE) begin
      if (hit_at < 0) begin
        r.status = ST_MISSING;
      end else begin
        for (i = hit_at; i < held_count - 1; i++) held_values[i] = held_values[i + 1];
        held_count--;
      end
    end
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offers one word, waits for its handshake, then records what should come back.
  task automatic offer_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                            input bit typed, input result_t want);
    result_t model;
    while (!tx_quiet && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model = apply_set_op(op, val);
    awaited_results.push_back(typed ? want : model);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 80) return value_pool[$urandom_range(POOL_N - 1)];
    return $urandom();
  endfunction

  // Insert-heavy, remove-heavy and balanced phases keep the table moving between
  // empty and full so that both the full and the missing paths get hit.
  function automatic logic [OP_W-1:0] pick_op(input int n);
    int roll;
    int ins_pct;
    int rem_pct;
    roll = $urandom_range(99);
    case ((n / 80) % 3)
      0: begin
        ins_pct = 60;
        rem_pct = 20;
      end
      1: begin
        ins_pct = 20;
        rem_pct = 60;
      end
      default: begin
        ins_pct = 35;
        rem_pct = 35;
      end
    endcase
    if (roll < ins_pct) return OP_INSERT;
    if (roll < ins_pct + rem_pct) return OP_REMOVE;
    if (roll < 95) return OP_QUERY;
    return OP_SPARE;
  endfunction

  initial begin : sender
    result_t want;
    int r;
    int k;
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_QUERY;
    held_count = 0;
    tx_quiet = 1'b0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (k = 4; k < POOL_N; k++) value_pool[k] = $urandom();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < $size(DIRECTED); r++) begin
      want.found = DIRECTED[r].found;
      want.count = DIRECTED[r].count;
      want.status = DIRECTED[r].status;
      for (k = 0; k < DIRECTED[r].reps; k++) begin
        offer_word(DIRECTED[r].op, DIRECTED[r].value + k, DIRECTED[r].typed, want);
      end
    end
    wait_drained();

    want = '0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      tx_quiet = (n >= 600 && n < 800);
      if (n == 500) wait_drained();
      if (n % 50 == 49) value_pool[$urandom_range(POOL_N - 1, 4)] = $urandom();
      offer_word(pick_op(n), pick_value(), 1'b0, want);
    end
    wait_drained();
    repeat (2 * CAPACITY + 10) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The receiver runs on its own cycle count: one long hold-off while words keep
  // coming, one stretch always ready, random back-pressure elsewhere.
  initial begin : receiver
    int cyc;
    m_tready = 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 8000 && cyc < 8300) begin
        m_tready <= 1'b0;
      end else if (cyc >= 12000 && cyc < 15000) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", m_tdata));
      end else begin
        want = awaited_results.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
